/* rtl/core/bsw_pkg.sv */
// Package: shared constants, types and segment tables for the B-spline shape weight.
package bsw_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int OFFSET_W      = 20;
  localparam int ORDER_W       = 3;
  localparam int SEG_W         = 2;
  localparam int NUM_SEG       = 3;
  localparam int WORK_BITS     = 30;
  localparam int ACC_W         = 33;
  localparam int U_W           = 32;
  localparam int HORNER_STEPS  = 5;
  localparam int COEF_IDX_W    = 3;

  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(1);

  // Q30 coefficients, nearest value of each fraction
  localparam logic signed [ACC_W-1:0] Q_ONE      = 33'sd1073741824;
  localparam logic signed [ACC_W-1:0] Q_3_4      = 33'sd805306368;
  localparam logic signed [ACC_W-1:0] Q_1_2      = 33'sd536870912;
  localparam logic signed [ACC_W-1:0] Q_2_3      = 33'sd715827883;
  localparam logic signed [ACC_W-1:0] Q_1_6      = 33'sd178956971;
  localparam logic signed [ACC_W-1:0] Q_1_4      = 33'sd268435456;
  localparam logic signed [ACC_W-1:0] Q_5_8      = 33'sd671088640;
  localparam logic signed [ACC_W-1:0] Q_115_192  = 33'sd643126613;
  localparam logic signed [ACC_W-1:0] Q_5_6      = 33'sd894784853;
  localparam logic signed [ACC_W-1:0] Q_5_4      = 33'sd1342177280;
  localparam logic signed [ACC_W-1:0] Q_5_24     = 33'sd223696213;
  localparam logic signed [ACC_W-1:0] Q_55_96    = 33'sd615164587;
  localparam logic signed [ACC_W-1:0] Q_1_24     = 33'sd44739243;
  localparam logic signed [ACC_W-1:0] Q_1_12     = 33'sd89478485;
  localparam logic signed [ACC_W-1:0] Q_11_20    = 33'sd590558003;
  localparam logic signed [ACC_W-1:0] Q_3_8      = 33'sd402653184;
  localparam logic signed [ACC_W-1:0] Q_7_4      = 33'sd1879048192;
  localparam logic signed [ACC_W-1:0] Q_17_40    = 33'sd456340275;
  localparam logic signed [ACC_W-1:0] Q_1_120    = 33'sd8947849;
  localparam logic signed [ACC_W-1:0] Q_ZERO     = '0;

  typedef struct packed {
    logic [2:0] end_halves;
    logic       inclusive;
    logic       mirrored;
  } seg_info_t;

  typedef struct packed {
    logic                    hit;
    logic [ORDER_W-1:0]      order;
    logic [SEG_W-1:0]        seg;
    logic [U_W-1:0]          u;
    logic signed [ACC_W-1:0] acc;
  } horner_t;

  typedef logic [0:5][ACC_W-1:0] coef_row_t;

  function automatic logic [SEG_W-1:0] seg_count(input logic [ORDER_W-1:0] order);
    case (order)
      3'd0, 3'd1: seg_count = 2'd1;
      3'd2, 3'd3: seg_count = 2'd2;
      3'd4, 3'd5: seg_count = 2'd3;
      default:    seg_count = 2'd0;
    endcase
  endfunction

  function automatic seg_info_t seg_info(input logic [ORDER_W-1:0] order,
                                         input logic [SEG_W-1:0] seg);
    case ({order, seg})
      {3'd0, 2'd0}: seg_info = '{3'd1, 1'b1, 1'b0};
      {3'd1, 2'd0}: seg_info = '{3'd2, 1'b1, 1'b0};
      {3'd2, 2'd0}: seg_info = '{3'd1, 1'b1, 1'b0};
      {3'd2, 2'd1}: seg_info = '{3'd3, 1'b0, 1'b1};
      {3'd3, 2'd0}: seg_info = '{3'd2, 1'b0, 1'b0};
      {3'd3, 2'd1}: seg_info = '{3'd4, 1'b0, 1'b1};
      {3'd4, 2'd0}: seg_info = '{3'd1, 1'b1, 1'b0};
      {3'd4, 2'd1}: seg_info = '{3'd3, 1'b1, 1'b0};
      {3'd4, 2'd2}: seg_info = '{3'd5, 1'b0, 1'b1};
      {3'd5, 2'd0}: seg_info = '{3'd2, 1'b1, 1'b0};
      {3'd5, 2'd1}: seg_info = '{3'd4, 1'b1, 1'b0};
      {3'd5, 2'd2}: seg_info = '{3'd6, 1'b0, 1'b1};
      default:      seg_info = '{3'd0, 1'b0, 1'b0};
    endcase
  endfunction

  // Highest power first, padded with leading zeros to five Horner steps
  function automatic logic signed [ACC_W-1:0] seg_coef(input logic [ORDER_W-1:0] order,
                                                       input logic [SEG_W-1:0] seg,
                                                       input logic [COEF_IDX_W-1:0] k);
    coef_row_t c;
    case ({order, seg})
      {3'd0, 2'd0}: c = '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE};
      {3'd1, 2'd0}: c = '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, -Q_ONE, Q_ONE};
      {3'd2, 2'd0}: c = '{Q_ZERO, Q_ZERO, Q_ZERO, -Q_ONE, Q_ZERO, Q_3_4};
      {3'd2, 2'd1}: c = '{Q_ZERO, Q_ZERO, Q_ZERO, Q_1_2, Q_ZERO, Q_ZERO};
      {3'd3, 2'd0}: c = '{Q_ZERO, Q_ZERO, Q_1_2, -Q_ONE, Q_ZERO, Q_2_3};
      {3'd3, 2'd1}: c = '{Q_ZERO, Q_ZERO, Q_1_6, Q_ZERO, Q_ZERO, Q_ZERO};
      {3'd4, 2'd0}: c = '{Q_ZERO, Q_1_4, Q_ZERO, -Q_5_8, Q_ZERO, Q_115_192};
      {3'd4, 2'd1}: c = '{Q_ZERO, -Q_1_6, Q_5_6, -Q_5_4, Q_5_24, Q_55_96};
      {3'd4, 2'd2}: c = '{Q_ZERO, Q_1_24, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO};
      {3'd5, 2'd0}: c = '{-Q_1_12, Q_1_4, Q_ZERO, -Q_1_2, Q_ZERO, Q_11_20};
      {3'd5, 2'd1}: c = '{Q_1_24, -Q_3_8, Q_5_4, -Q_7_4, Q_5_8, Q_17_40};
      {3'd5, 2'd2}: c = '{Q_1_120, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO};
      default:      c = '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO};
    endcase
    if (k > COEF_IDX_W'(HORNER_STEPS)) begin
      seg_coef = Q_ZERO;
    end else begin
      seg_coef = $signed(c[k]);
    end
  endfunction

endpackage

/* rtl/core/bsw_if.sv */
// Interfaces: offset and weight stream channels with valid/ready handshake.
interface bsw_offset_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bsw_pkg::OFFSET_W-1:0]   offset;

  modport source (output valid, output offset, input ready);
  modport sink   (input valid, input offset, output ready);
endinterface

interface bsw_weight_if #(parameter int FRAC_BITS = bsw_pkg::FRAC_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   weight;

  modport source (output valid, output weight, input ready);
  modport sink   (input valid, input weight, output ready);
endinterface

/* rtl/core/bspline_shape_weight.sv */
// Pipeline: eight register stages, namely magnitude, segment pick, five Horner multiply-add
// stages and rounding; the result is offered from the rounding stage register.
// Throughput: one transaction per cycle while the output is not stalled; a stalled output
// holds each full stage back to the first empty one. Nothing is dropped or repeated.
// Reset (rst, synchronous): clears all stage valid bits and sets spline_order to 1.
module bspline_shape_weight #(
  parameter int FRAC_BITS = bsw_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         spline_order_we,
  input  logic [bsw_pkg::ORDER_W-1:0]  spline_order_wdata,
  bsw_offset_if.sink                   offset_ch,
  bsw_weight_if.source                 weight_ch
);
  import bsw_pkg::*;

  localparam int SH      = WORK_BITS - FRAC_BITS;
  localparam int XW      = OFFSET_W + SH;
  localparam int CMP_W   = (XW > ACC_W) ? XW : ACC_W;
  localparam int NST     = HORNER_STEPS + 3;
  localparam int OUT_ST  = NST - 1;
  localparam int RND_ST  = HORNER_STEPS + 1;
  localparam int PROD_W  = ACC_W + U_W + 1;
  localparam int SUM_W   = ACC_W + 1;
  localparam int W_W     = FRAC_BITS + 1;

  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((PROD_W'(1) << WORK_BITS) - 1);
  localparam logic [SUM_W-1:0]         HALF       = (SUM_W'(1) << SH) >> 1;
  localparam logic [SUM_W-1:0]         W_ONE      = SUM_W'(1) << FRAC_BITS;

  logic [ORDER_W-1:0]   spline_order;
  logic [NST-1:0]       v;
  logic [NST-1:0]       adv;
  logic [OFFSET_W-1:0]  mag;
  logic [OFFSET_W-1:0]  mag_in;
  logic [ORDER_W-1:0]   mag_order;
  horner_t              hp [0:HORNER_STEPS];
  logic [W_W-1:0]       wgt;
  logic [W_W-1:0]       wgt_next;

  logic [CMP_W-1:0]     x;
  logic [CMP_W-1:0]     ends [NUM_SEG];
  logic [NUM_SEG-1:0]   in_seg;
  logic [NUM_SEG-1:0]   mirr;
  logic [SEG_W-1:0]     sel;
  logic                 hit;
  logic [CMP_W-1:0]     u_full;

  logic                 pos;
  logic [SUM_W-1:0]     rsum;
  logic [SUM_W-1:0]     rw;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      spline_order <= ORDER_RESET;
    end else if (spline_order_we) begin
      spline_order <= spline_order_wdata;
    end
  end

  // stage advance: a stage moves when empty or when its successor moves
  always_comb begin
    adv[OUT_ST] = !v[OUT_ST] || weight_ch.ready;
    for (int i = OUT_ST - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign offset_ch.ready  = adv[0];
  assign weight_ch.valid  = v[OUT_ST];
  assign weight_ch.weight = wgt;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= offset_ch.valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 0: magnitude
  assign mag_in = offset_ch.offset[OFFSET_W-1] ? OFFSET_W'($unsigned(~offset_ch.offset) + 1'b1)
                                               : OFFSET_W'($unsigned(offset_ch.offset));

  always_ff @(posedge clk) begin
    if (adv[0] && offset_ch.valid) begin
      mag       <= mag_in;
      mag_order <= spline_order;
    end
  end

  // stage 1: segment pick and Horner argument
  always_comb begin
    seg_info_t info;
    x = CMP_W'(mag) << SH;
    for (int s = 0; s < NUM_SEG; s++) begin
      info      = seg_info(mag_order, SEG_W'(s));
      ends[s]   = CMP_W'(info.end_halves) << (WORK_BITS - 1);
      mirr[s]   = info.mirrored;
      in_seg[s] = (SEG_W'(s) < seg_count(mag_order)) &&
                  (info.inclusive ? (x <= ends[s]) : (x < ends[s]));
    end
    sel = '0;
    for (int s = NUM_SEG - 1; s >= 0; s--) begin
      if (in_seg[s]) begin
        sel = SEG_W'(s);
      end
    end
    hit    = |in_seg;
    u_full = mirr[sel] ? (ends[sel] - x) : x;
  end

  always_ff @(posedge clk) begin
    if (adv[1] && v[0]) begin
      hp[0].hit   <= hit;
      hp[0].order <= mag_order;
      hp[0].seg   <= sel;
      hp[0].u     <= U_W'(u_full);
      hp[0].acc   <= seg_coef(mag_order, sel, COEF_IDX_W'(0));
    end
  end

  // stages 2..6: one truncating multiply-add each
  for (genvar k = 1; k <= HORNER_STEPS; k++) begin : g_horner
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [PROD_W-1:0] quot;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb begin
      prod     = $signed(hp[k-1].acc) * $signed({1'b0, hp[k-1].u});
      prod_adj = prod[PROD_W-1] ? (prod + TRUNC_BIAS) : prod;
      quot     = prod_adj >>> WORK_BITS;
      acc_next = ACC_W'(quot) + seg_coef(hp[k-1].order, hp[k-1].seg, COEF_IDX_W'(k));
    end

    always_ff @(posedge clk) begin
      if (adv[k+1] && v[k]) begin
        hp[k].hit   <= hp[k-1].hit;
        hp[k].order <= hp[k-1].order;
        hp[k].seg   <= hp[k-1].seg;
        hp[k].u     <= hp[k-1].u;
        hp[k].acc   <= acc_next;
      end
    end
  end

  // stage 7: round to nearest, clamp
  always_comb begin
    pos      = hp[HORNER_STEPS].hit && !hp[HORNER_STEPS].acc[ACC_W-1] &&
               (hp[HORNER_STEPS].acc != '0);
    rsum     = {1'b0, $unsigned(hp[HORNER_STEPS].acc)} + HALF;
    rw       = rsum >> SH;
    if (!pos) begin
      wgt_next = '0;
    end else if (rw > W_ONE) begin
      wgt_next = W_W'(W_ONE);
    end else begin
      wgt_next = W_W'(rw);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUT_ST] && v[RND_ST]) begin
      wgt <= wgt_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_weight_le_one: assert property (@(posedge clk) disable iff (rst)
    weight_ch.valid |-> (SUM_W'(weight_ch.weight) <= W_ONE))
    else $error("weight above one");

  a_miss_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (v[RND_ST] && adv[OUT_ST] && !hp[HORNER_STEPS].hit) |=>
    (weight_ch.valid && (weight_ch.weight == '0)))
    else $error("offset outside support gave nonzero weight");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !offset_ch.ready |-> ((&v) && !weight_ch.ready))
    else $error("input stalled with a free stage");
`endif

endmodule

/* sim/bsw_weight_checker.sv */
// Checker: predicts the B-spline shape weight of every offset transaction and compares results.
module bsw_weight_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              order_we,
  input  logic [bsw_pkg::ORDER_W-1:0]       order_wdata,
  input  logic                              offset_valid,
  input  logic                              offset_ready,
  input  logic [bsw_pkg::OFFSET_W-1:0]      offset,
  input  logic                              weight_valid,
  input  logic                              weight_ready,
  input  logic [bsw_pkg::FRAC_BITS_DEF:0]   weight,
  output int                                weights_due,
  output int                                weight_errors
);
  import bsw_pkg::*;

  localparam int     WEIGHT_W = FRAC_BITS_DEF + 1;
  localparam int     SHIFT    = WORK_BITS - FRAC_BITS_DEF;
  localparam longint WORK_ONE = 64'sd1 <<< WORK_BITS;
  localparam longint W_ONE    = 64'sd1 <<< FRAC_BITS_DEF;

  typedef struct packed {
    logic [OFFSET_W-1:0] off;
    logic [ORDER_W-1:0]  order;
    logic [WEIGHT_W-1:0] weight;
  } weight_due_t;

  weight_due_t        expected_weights[$];
  logic [ORDER_W-1:0] order_q;

  // nearest Q30 value of n/d
  function automatic longint q30(input int n, input int d);
    return ((longint'(n) <<< 31) + d) / (2 * longint'(d));
  endfunction

  function automatic logic [WEIGHT_W-1:0] weight_for(input logic [ORDER_W-1:0] order,
                                                      input logic [OFFSET_W-1:0] raw);
    longint coef [6];
    longint x, seg_end, u, acc, w;
    int     halves, degree;
    bit     closed, mirror, hit;
    hit = 1'b0;
    acc = 0;
    x = raw[OFFSET_W-1] ? longint'(21'h100000 - {1'b0, raw}) : longint'(raw);
    x = x <<< SHIFT;
    for (int s = 0; s < NUM_SEG; s++) begin
      halves = 0;
      degree = 0;
      closed = 1'b0;
      mirror = 1'b0;
      coef = '{default: 0};
      case ({order, s[1:0]})
        {3'd0, 2'd0}: begin
          halves = 1; closed = 1'b1;
          coef = '{q30(1, 1), 0, 0, 0, 0, 0};
        end
        {3'd1, 2'd0}: begin
          halves = 2; closed = 1'b1; degree = 1;
          coef = '{-q30(1, 1), q30(1, 1), 0, 0, 0, 0};
        end
        {3'd2, 2'd0}: begin
          halves = 1; closed = 1'b1; degree = 2;
          coef = '{-q30(1, 1), 0, q30(3, 4), 0, 0, 0};
        end
        {3'd2, 2'd1}: begin
          halves = 3; mirror = 1'b1; degree = 2;
          coef = '{q30(1, 2), 0, 0, 0, 0, 0};
        end
        {3'd3, 2'd0}: begin
          halves = 2; degree = 3;
          coef = '{q30(1, 2), -q30(1, 1), 0, q30(2, 3), 0, 0};
        end
        {3'd3, 2'd1}: begin
          halves = 4; mirror = 1'b1; degree = 3;
          coef = '{q30(1, 6), 0, 0, 0, 0, 0};
        end
        {3'd4, 2'd0}: begin
          halves = 1; closed = 1'b1; degree = 4;
          coef = '{q30(1, 4), 0, -q30(5, 8), 0, q30(115, 192), 0};
        end
        {3'd4, 2'd1}: begin
          halves = 3; closed = 1'b1; degree = 4;
          coef = '{-q30(1, 6), q30(5, 6), -q30(5, 4), q30(5, 24), q30(55, 96), 0};
        end
        {3'd4, 2'd2}: begin
          halves = 5; mirror = 1'b1; degree = 4;
          coef = '{q30(1, 24), 0, 0, 0, 0, 0};
        end
        {3'd5, 2'd0}: begin
          halves = 2; closed = 1'b1; degree = 5;
          coef = '{-q30(1, 12), q30(1, 4), 0, -q30(1, 2), 0, q30(11, 20)};
        end
        {3'd5, 2'd1}: begin
          halves = 4; closed = 1'b1; degree = 5;
          coef = '{q30(1, 24), -q30(3, 8), q30(5, 4), -q30(7, 4), q30(5, 8), q30(17, 40)};
        end
        {3'd5, 2'd2}: begin
          halves = 6; mirror = 1'b1; degree = 5;
          coef = '{q30(1, 120), 0, 0, 0, 0, 0};
        end
        default: halves = 0;
      endcase
      if (!hit && halves != 0) begin
        seg_end = longint'(halves) <<< (WORK_BITS - 1);
        if (closed ? (x <= seg_end) : (x < seg_end)) begin
          u = mirror ? seg_end - x : x;
          acc = coef[0];
          for (int k = 1; k <= degree; k++) begin
            acc = (acc * u) / WORK_ONE + coef[k];
          end
          hit = 1'b1;
        end
      end
    end
    if (!hit || acc <= 0) begin
      return '0;
    end
    w = (acc + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
    if (w > W_ONE) begin
      w = W_ONE;
    end
    return WEIGHT_W'(w);
  endfunction

  always @(posedge clk) begin
    weight_due_t head;
    if (rst) begin
      order_q = ORDER_RESET;
      weight_errors = 0;
      expected_weights.delete();
    end else begin
      if (weight_valid && weight_ready) begin
        if (expected_weights.size() == 0) begin
          if (weight_errors < 10) begin
            $display("unexpected weight %0d with nothing outstanding", weight);
          end
          weight_errors = weight_errors + 1;
        end else begin
          head = expected_weights.pop_front();
          if (weight !== head.weight) begin
            if (weight_errors < 10) begin
              $display("weight error: offset %0d order %0d expected %0d got %0d",
                       $signed(head.off), head.order, head.weight, weight);
            end
            weight_errors = weight_errors + 1;
          end
        end
      end
      if (offset_valid && offset_ready) begin
        expected_weights.push_back('{offset, order_q, weight_for(order_q, offset)});
      end
      if (order_we) begin
        order_q = order_wdata;
      end
    end
    weights_due <= expected_weights.size();
  end

endmodule

/* sim/testbench.sv */
// Testbench top: drives offsets and spline order settings into the shape weight block.
module testbench;
  import bsw_pkg::*;

  logic               clk;
  logic               rst;
  logic               order_we;
  logic [ORDER_W-1:0] order_wdata;
  int                 weights_due;
  int                 weight_errors;
  bit                 src_idle;
  bit                 snk_idle;

  // segment ends, their neighbours and the field extremes
  int probe_offsets [18] = '{0, 1, -1, 32767, 32768, -32768, 32769, 65535, 65536, -65536,
                             65537, 98304, -98304, 131072, 163840, 196608, 524287, -524288};
  logic [ORDER_W-1:0] phase_orders [10] = '{3'd1, 3'd0, 3'd5, 3'd2, 3'd7,
                                            3'd3, 3'd4, 3'd6, 3'd5, 3'd1};

  bsw_offset_if offset_bus ();
  bsw_weight_if weight_bus ();

  bspline_shape_weight uut (
    .clk                (clk),
    .rst                (rst),
    .spline_order_we    (order_we),
    .spline_order_wdata (order_wdata),
    .offset_ch          (offset_bus),
    .weight_ch          (weight_bus)
  );

  bsw_weight_checker weight_check (
    .clk           (clk),
    .rst           (rst),
    .order_we      (order_we),
    .order_wdata   (order_wdata),
    .offset_valid  (offset_bus.valid),
    .offset_ready  (offset_bus.ready),
    .offset        (offset_bus.offset),
    .weight_valid  (weight_bus.valid),
    .weight_ready  (weight_bus.ready),
    .weight        (weight_bus.weight),
    .weights_due   (weights_due),
    .weight_errors (weight_errors)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic send_offset(input int value);
    int gap;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      offset_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offset_bus.valid <= 1'b1;
    offset_bus.offset <= OFFSET_W'(value);
    do @(posedge clk); while (!offset_bus.ready);
  endtask

  // stop sending and wait for every outstanding weight
  task automatic drain_weights();
    offset_bus.valid <= 1'b0;
    @(posedge clk);
    while (weights_due != 0) @(posedge clk);
  endtask

  task automatic write_order(input logic [ORDER_W-1:0] value);
    order_we <= 1'b1;
    order_wdata <= value;
    @(posedge clk);
    order_we <= 1'b0;
  endtask

  // mostly near segment ends or up to half a unit past the widest support, some raw patterns
  function automatic int random_offset();
    int pick;
    int mag;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      mag = int'(32768 * $urandom_range(0, 7)) + int'($urandom_range(0, 6)) - 3;
      if (mag < 0) begin
        mag = -mag;
      end
    end else if (pick < 8) begin
      mag = $urandom_range(0, 229376);
    end else begin
      return int'($urandom_range(0, 20'hFFFFF));
    end
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  initial begin
    rst <= 1'b1;
    order_we <= 1'b0;
    order_wdata <= '0;
    offset_bus.valid <= 1'b0;
    offset_bus.offset <= '0;
    src_idle = 1'b0;
    snk_idle = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (probe_offsets[i]) begin
      send_offset(probe_offsets[i]);
    end
    for (int p = 0; p < 10; p++) begin
      if (p > 0) begin
        drain_weights();
        write_order(phase_orders[p]);
      end
      src_idle = p[0];
      snk_idle = p[1];
      repeat (88) send_offset(random_offset());
    end
    drain_weights();
    repeat (16) @(posedge clk);
    if (weight_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int stall;
    weight_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = snk_idle ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        weight_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      weight_bus.ready <= 1'b1;
      do @(posedge clk); while (!weight_bus.valid);
    end
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bsw_pkg.sv
rtl/core/bsw_if.sv
rtl/core/bspline_shape_weight.sv
sim/bsw_weight_checker.sv
sim/testbench.sv
